@@ src/grc_pkg.sv @@
package grc_pkg;

   localparam int COORD_W    = 15;
   localparam int ANGLE_W    = 12;
   localparam int MAP_W      = 64;
   localparam int CELL_SHIFT = 12;
   localparam int CELL_UNIT  = 1 << CELL_SHIFT;
   localparam int MAX_STEPS  = 8;
   localparam int CORDIC_N   = 20;
   localparam int CORDIC_W   = 33;
   localparam int ANG_ACC_W  = 32;
   localparam int MAG_W      = 31;
   localparam int REM_W      = 32;
   localparam int NUM_W      = 48;
   localparam int SLOPE_W    = 25;
   localparam int SPAN_W     = 16;
   localparam int PROD_W     = SPAN_W + SLOPE_W;
   localparam int POS_W      = 28;
   localparam int SQ_W       = 31;
   localparam int DIST_W     = 32;
   localparam int IDX_W      = 6;

   localparam logic [SLOPE_W-1:0] SLOPE_SAT   = SLOPE_W'(1 << 24);
   localparam logic [COORD_W-1:0] COORD_MAX   = '1;
   localparam logic [ANGLE_W-1:0] ANGLE_ZERO  = ANGLE_W'(0);
   localparam logic [ANGLE_W-1:0] ANGLE_QUART = ANGLE_W'(1024);
   localparam logic [ANGLE_W-1:0] ANGLE_HALF  = ANGLE_W'(2048);
   localparam logic [ANGLE_W-1:0] ANGLE_3QUART = ANGLE_W'(3072);

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic               x_zero;
      logic               x_neg;
      logic               y_zero;
      logic               y_neg;
   } ray_type;

   typedef struct packed {
      ray_type              ray;
      logic                 h_hit;
      logic [COORD_W-1:0]   hx;
      logic [COORD_W:0]     hy;
      logic                 v_hit;
      logic [COORD_W:0]     vx;
      logic [COORD_W-1:0]   vy;
   } cast_type;

   function automatic logic signed [ANG_ACC_W-1:0] arc_angle(input int idx);
      logic signed [ANG_ACC_W-1:0] val;
      unique case (idx)
         0: val = 536870912;
         1: val = 316933406;
         2: val = 167458907;
         3: val = 85004756;
         4: val = 42667331;
         5: val = 21354465;
         6: val = 10679838;
         7: val = 5340245;
         8: val = 2670163;
         9: val = 1335087;
         10: val = 667544;
         11: val = 333772;
         12: val = 166886;
         13: val = 83443;
         14: val = 41722;
         15: val = 20861;
         16: val = 10430;
         17: val = 5215;
         18: val = 2608;
         19: val = 1304;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ src/grc_cordic.sv @@
module grc_cordic import grc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ANGLE_W-1:0]         in_angle,
   input  ray_type                    in_ray,
   output logic                       out_valid,
   output logic signed [CORDIC_W-1:0] out_x,
   output logic signed [CORDIC_W-1:0] out_y,
   output logic                       out_odd,
   output ray_type                    out_ray
);

   logic                       valid_ff [CORDIC_N];
   logic signed [CORDIC_W-1:0] x_ff     [CORDIC_N];
   logic signed [CORDIC_W-1:0] y_ff     [CORDIC_N];
   logic signed [ANG_ACC_W-1:0] z_ff    [CORDIC_N];
   logic                       odd_ff   [CORDIC_N];
   ray_type                    ray_ff   [CORDIC_N];

   logic                       src_valid [CORDIC_N];
   logic signed [CORDIC_W-1:0] src_x     [CORDIC_N];
   logic signed [CORDIC_W-1:0] src_y     [CORDIC_N];
   logic signed [ANG_ACC_W-1:0] src_z    [CORDIC_N];
   logic                       src_odd   [CORDIC_N];
   ray_type                    src_ray   [CORDIC_N];

   assign src_valid[0] = in_valid;
   assign src_x[0]     = CORDIC_W'(1 << 30);
   assign src_y[0]     = '0;
   assign src_z[0]     = $signed({2'b00, in_angle[ANGLE_W-3:0], 20'b0});
   assign src_odd[0]   = in_angle[ANGLE_W-2];
   assign src_ray[0]   = in_ray;

   for (genvar k = 1; k < CORDIC_N; k++) begin : g_link
      assign src_valid[k] = valid_ff[k-1];
      assign src_x[k]     = x_ff[k-1];
      assign src_y[k]     = y_ff[k-1];
      assign src_z[k]     = z_ff[k-1];
      assign src_odd[k]   = odd_ff[k-1];
      assign src_ray[k]   = ray_ff[k-1];
   end

   for (genvar k = 0; k < CORDIC_N; k++) begin : g_stage
      logic signed [CORDIC_W-1:0]  x_in;
      logic signed [CORDIC_W-1:0]  y_in;
      logic signed [ANG_ACC_W-1:0] z_in;

      always_comb begin
         if (src_z[k] >= 0) begin
            x_in = src_x[k] - (src_y[k] >>> k);
            y_in = src_y[k] + (src_x[k] >>> k);
            z_in = src_z[k] - arc_angle(k);
         end else begin
            x_in = src_x[k] + (src_y[k] >>> k);
            y_in = src_y[k] - (src_x[k] >>> k);
            z_in = src_z[k] + arc_angle(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid[k];
            x_ff[k]     <= x_in;
            y_ff[k]     <= y_in;
            z_ff[k]     <= z_in;
            odd_ff[k]   <= src_odd[k];
            ray_ff[k]   <= src_ray[k];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_N-1];
   assign out_x     = x_ff[CORDIC_N-1];
   assign out_y     = y_ff[CORDIC_N-1];
   assign out_odd   = odd_ff[CORDIC_N-1];
   assign out_ray   = ray_ff[CORDIC_N-1];

endmodule

@@ src/grc_slope.sv @@
module grc_slope import grc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [CORDIC_W-1:0] in_x,
   input  logic signed [CORDIC_W-1:0] in_y,
   input  logic                       in_odd,
   input  ray_type                    in_ray,
   output logic                       out_valid,
   output logic [SLOPE_W-1:0]         out_tan,
   output logic [SLOPE_W-1:0]         out_cot,
   output ray_type                    out_ray
);

   typedef struct packed {
      logic [REM_W-1:0]   rem;
      logic [SLOPE_W-1:0] low;
      logic [SLOPE_W-1:0] quo;
      logic [MAG_W-1:0]   den;
      logic               sat;
   } div_type;

   function automatic div_type div_init(input logic [MAG_W-1:0] n, input logic [MAG_W-1:0] d);
      logic [NUM_W-1:0] num;
      div_type          res;
      num     = NUM_W'({n, 16'b0}) + NUM_W'(d >> 1);
      res.rem = REM_W'(num[NUM_W-1:SLOPE_W]);
      res.low = num[SLOPE_W-1:0];
      res.quo = '0;
      res.den = d;
      res.sat = {8'b0, n} >= {d, 8'b0};
      return res;
   endfunction

   function automatic div_type div_step(input div_type cur);
      logic [REM_W:0] trial;
      div_type        nxt;
      trial   = {cur.rem, cur.low[SLOPE_W-1]};
      nxt     = cur;
      nxt.low = cur.low << 1;
      if (trial >= {2'b00, cur.den}) begin
         nxt.rem = REM_W'(trial - {2'b00, cur.den});
         nxt.quo = {cur.quo[SLOPE_W-2:0], 1'b1};
      end else begin
         nxt.rem = REM_W'(trial);
         nxt.quo = {cur.quo[SLOPE_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic               mag_valid_ff;
   logic [MAG_W-1:0]   sm_ff;
   logic [MAG_W-1:0]   cm_ff;
   ray_type            mag_ray_ff;
   logic [MAG_W-1:0]   ax;
   logic [MAG_W-1:0]   ay;

   logic               valid_ff [SLOPE_W+1];
   div_type            tan_ff   [SLOPE_W+1];
   div_type            cot_ff   [SLOPE_W+1];
   ray_type            ray_ff   [SLOPE_W+1];

   always_comb begin
      ax = MAG_W'(in_x < 0 ? -in_x : in_x);
      ay = MAG_W'(in_y < 0 ? -in_y : in_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (en) begin
         mag_valid_ff <= in_valid;
         sm_ff        <= in_odd ? ax : ay;
         cm_ff        <= in_odd ? ay : ax;
         mag_ray_ff   <= in_ray;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= mag_valid_ff;
         tan_ff[0]   <= div_init(sm_ff, cm_ff);
         cot_ff[0]   <= div_init(cm_ff, sm_ff);
         ray_ff[0]   <= mag_ray_ff;
      end
   end

   for (genvar s = 1; s <= SLOPE_W; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_ff[s-1];
            tan_ff[s]   <= div_step(tan_ff[s-1]);
            cot_ff[s]   <= div_step(cot_ff[s-1]);
            ray_ff[s]   <= ray_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[SLOPE_W];
   assign out_tan   = tan_ff[SLOPE_W].sat ? SLOPE_SAT : tan_ff[SLOPE_W].quo;
   assign out_cot   = cot_ff[SLOPE_W].sat ? SLOPE_SAT : cot_ff[SLOPE_W].quo;
   assign out_ray   = ray_ff[SLOPE_W];

endmodule

@@ src/grc_walk.sv @@
module grc_walk import grc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [MAP_W-1:0]   wall_map,
   input  logic               in_valid,
   input  logic [SLOPE_W-1:0] in_tan,
   input  logic [SLOPE_W-1:0] in_cot,
   input  ray_type            in_ray,
   output logic               out_valid,
   output cast_type           out_cast
);

   logic               a_valid_ff  [MAX_STEPS];
   cast_type           a_cast_ff   [MAX_STEPS];
   logic [SLOPE_W-1:0] a_tan_ff    [MAX_STEPS];
   logic [SLOPE_W-1:0] a_cot_ff    [MAX_STEPS];
   logic [PROD_W-1:0]  a_prod_h_ff [MAX_STEPS];
   logic [PROD_W-1:0]  a_prod_v_ff [MAX_STEPS];

   logic               b_valid_ff  [MAX_STEPS];
   cast_type           b_cast_ff   [MAX_STEPS];
   logic [SLOPE_W-1:0] b_tan_ff    [MAX_STEPS];
   logic [SLOPE_W-1:0] b_cot_ff    [MAX_STEPS];

   logic               s_valid [MAX_STEPS];
   cast_type           s_cast  [MAX_STEPS];
   logic [SLOPE_W-1:0] s_tan   [MAX_STEPS];
   logic [SLOPE_W-1:0] s_cot   [MAX_STEPS];

   always_comb begin
      s_cast[0]     = '0;
      s_cast[0].ray = in_ray;
   end
   assign s_valid[0] = in_valid;
   assign s_tan[0]   = in_tan;
   assign s_cot[0]   = in_cot;

   for (genvar k = 1; k < MAX_STEPS; k++) begin : g_link
      assign s_valid[k] = b_valid_ff[k-1];
      assign s_cast[k]  = b_cast_ff[k-1];
      assign s_tan[k]   = b_tan_ff[k-1];
      assign s_cot[k]   = b_cot_ff[k-1];
   end

   for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
      logic [SPAN_W-1:0]  m_h;
      logic [SPAN_W-1:0]  m_v;
      logic [PROD_W:0]    rnd_h;
      logic [PROD_W:0]    rnd_v;
      logic [POS_W-1:0]   off_h;
      logic [POS_W-1:0]   off_v;
      logic [POS_W-1:0]   ex;
      logic [POS_W-1:0]   ey;
      logic [IDX_W-1:0]   row_h;
      logic [IDX_W-1:0]   line_h;
      logic [IDX_W-1:0]   col_v;
      logic [IDX_W-1:0]   line_v;
      ray_type            ra;
      ray_type            rb;
      cast_type           cast_in;

      always_comb begin
         ra  = s_cast[k].ray;
         m_h = (ra.y_neg ? SPAN_W'(ra.py[CELL_SHIFT-1:0])
                         : SPAN_W'(CELL_UNIT) - SPAN_W'(ra.py[CELL_SHIFT-1:0]))
               + SPAN_W'(k * CELL_UNIT);
         m_v = (ra.x_neg ? SPAN_W'(ra.px[CELL_SHIFT-1:0])
                         : SPAN_W'(CELL_UNIT) - SPAN_W'(ra.px[CELL_SHIFT-1:0]))
               + SPAN_W'(k * CELL_UNIT);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff[k] <= 1'b0;
         end else if (en) begin
            a_valid_ff[k]  <= s_valid[k];
            a_cast_ff[k]   <= s_cast[k];
            a_tan_ff[k]    <= s_tan[k];
            a_cot_ff[k]    <= s_cot[k];
            a_prod_h_ff[k] <= PROD_W'(m_h) * PROD_W'(s_cot[k]);
            a_prod_v_ff[k] <= PROD_W'(m_v) * PROD_W'(s_tan[k]);
         end
      end

      always_comb begin
         rb      = a_cast_ff[k].ray;
         cast_in = a_cast_ff[k];
         rnd_h   = (PROD_W+1)'(a_prod_h_ff[k]) + (PROD_W+1)'(1 << 15);
         rnd_v   = (PROD_W+1)'(a_prod_v_ff[k]) + (PROD_W+1)'(1 << 15);
         off_h   = POS_W'(rnd_h >> 16);
         off_v   = POS_W'(rnd_v >> 16);

         if (rb.x_zero) begin
            ex = POS_W'(rb.px);
         end else if (rb.x_neg) begin
            ex = POS_W'(rb.px) - off_h;
         end else begin
            ex = POS_W'(rb.px) + off_h;
         end
         if (rb.y_zero) begin
            ey = POS_W'(rb.py);
         end else if (rb.y_neg) begin
            ey = POS_W'(rb.py) - off_v;
         end else begin
            ey = POS_W'(rb.py) + off_v;
         end

         row_h  = rb.y_neg ? IDX_W'(rb.py[COORD_W-1:CELL_SHIFT]) - IDX_W'(1) - IDX_W'(k)
                           : IDX_W'(rb.py[COORD_W-1:CELL_SHIFT]) + IDX_W'(1) + IDX_W'(k);
         line_h = row_h + IDX_W'(rb.y_neg);
         col_v  = rb.x_neg ? IDX_W'(rb.px[COORD_W-1:CELL_SHIFT]) - IDX_W'(1) - IDX_W'(k)
                           : IDX_W'(rb.px[COORD_W-1:CELL_SHIFT]) + IDX_W'(1) + IDX_W'(k);
         line_v = col_v + IDX_W'(rb.x_neg);

         if (!rb.y_zero && !cast_in.h_hit && ex[POS_W-1:COORD_W] == '0
             && row_h[IDX_W-1:3] == '0
             && wall_map[{row_h[2:0], ex[COORD_W-1:CELL_SHIFT]}]) begin
            cast_in.h_hit = 1'b1;
            cast_in.hx    = ex[COORD_W-1:0];
            cast_in.hy    = {line_h[3:0], 12'b0};
         end
         if (!rb.x_zero && !cast_in.v_hit && ey[POS_W-1:COORD_W] == '0
             && col_v[IDX_W-1:3] == '0
             && wall_map[{ey[COORD_W-1:CELL_SHIFT], col_v[2:0]}]) begin
            cast_in.v_hit = 1'b1;
            cast_in.vx    = {line_v[3:0], 12'b0};
            cast_in.vy    = ey[COORD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            b_valid_ff[k] <= 1'b0;
         end else if (en) begin
            b_valid_ff[k] <= a_valid_ff[k];
            b_cast_ff[k]  <= cast_in;
            b_tan_ff[k]   <= a_tan_ff[k];
            b_cot_ff[k]   <= a_cot_ff[k];
         end
      end
   end

   assign out_valid = b_valid_ff[MAX_STEPS-1];
   assign out_cast  = b_cast_ff[MAX_STEPS-1];

endmodule

@@ src/grc_pick.sv @@
module grc_pick import grc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  cast_type           in_cast,
   output logic               out_valid,
   output logic [COORD_W-1:0] out_hit_x,
   output logic [COORD_W-1:0] out_hit_y,
   output logic               out_hit_found,
   output logic               out_hit_side
);

   logic                        p_valid_ff;
   cast_type                    p_cast_ff;
   logic [SQ_W-1:0]             sq_hx_ff;
   logic [SQ_W-1:0]             sq_hy_ff;
   logic [SQ_W-1:0]             sq_vx_ff;
   logic [SQ_W-1:0]             sq_vy_ff;

   logic signed [COORD_W+1:0]   d_hx;
   logic signed [COORD_W+1:0]   d_hy;
   logic signed [COORD_W+1:0]   d_vx;
   logic signed [COORD_W+1:0]   d_vy;
   logic signed [2*COORD_W+3:0] p_hx;
   logic signed [2*COORD_W+3:0] p_hy;
   logic signed [2*COORD_W+3:0] p_vx;
   logic signed [2*COORD_W+3:0] p_vy;

   logic [DIST_W-1:0]           dist_h;
   logic [DIST_W-1:0]           dist_v;
   logic                        take_h;

   logic                        out_valid_ff;
   logic [COORD_W-1:0]          hit_x_ff;
   logic [COORD_W-1:0]          hit_y_ff;
   logic                        hit_found_ff;
   logic                        hit_side_ff;

   always_comb begin
      d_hx = $signed({2'b00, in_cast.hx}) - $signed({2'b00, in_cast.ray.px});
      d_hy = $signed({1'b0, in_cast.hy}) - $signed({2'b00, in_cast.ray.py});
      d_vx = $signed({1'b0, in_cast.vx}) - $signed({2'b00, in_cast.ray.px});
      d_vy = $signed({2'b00, in_cast.vy}) - $signed({2'b00, in_cast.ray.py});
      p_hx = d_hx * d_hx;
      p_hy = d_hy * d_hy;
      p_vx = d_vx * d_vx;
      p_vy = d_vy * d_vy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
         p_cast_ff  <= in_cast;
         sq_hx_ff   <= SQ_W'(p_hx);
         sq_hy_ff   <= SQ_W'(p_hy);
         sq_vx_ff   <= SQ_W'(p_vx);
         sq_vy_ff   <= SQ_W'(p_vy);
      end
   end

   always_comb begin
      dist_h = DIST_W'(sq_hx_ff) + DIST_W'(sq_hy_ff);
      dist_v = DIST_W'(sq_vx_ff) + DIST_W'(sq_vy_ff);
      take_h = p_cast_ff.h_hit && (!p_cast_ff.v_hit || dist_h <= dist_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= p_valid_ff;
         priority if (take_h) begin
            hit_x_ff     <= p_cast_ff.hx;
            hit_y_ff     <= p_cast_ff.hy[COORD_W] ? COORD_MAX : p_cast_ff.hy[COORD_W-1:0];
            hit_found_ff <= 1'b1;
            hit_side_ff  <= 1'b0;
         end else if (p_cast_ff.v_hit) begin
            hit_x_ff     <= p_cast_ff.vx[COORD_W] ? COORD_MAX : p_cast_ff.vx[COORD_W-1:0];
            hit_y_ff     <= p_cast_ff.vy;
            hit_found_ff <= 1'b1;
            hit_side_ff  <= 1'b1;
         end else begin
            hit_x_ff     <= p_cast_ff.ray.px;
            hit_y_ff     <= p_cast_ff.ray.py;
            hit_found_ff <= 1'b0;
            hit_side_ff  <= 1'b0;
         end
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_hit_x     = hit_x_ff;
   assign out_hit_y     = hit_y_ff;
   assign out_hit_found = hit_found_ff;
   assign out_hit_side  = hit_side_ff;

endmodule

@@ src/grid_ray_cast.sv @@
// Throughput: one request per cycle while no result is stalled; every stage of
// the CORDIC, the two slope dividers, the sixteen grid-walk stages and the
// distance compare is registered.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and the wall map to zero.
module grid_ray_cast import grc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [ANGLE_W-1:0] req_ray_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_hit_x,
   output logic [COORD_W-1:0] rsp_hit_y,
   output logic               rsp_hit_found,
   output logic               rsp_hit_side,
   input  logic               csr_write_enable,
   input  logic [MAP_W-1:0]   csr_write_data
);

   logic [MAP_W-1:0]          wall_map_ff;
   logic                      en;
   ray_type                   in_ray;

   logic                      cor_valid;
   logic signed [CORDIC_W-1:0] cor_x;
   logic signed [CORDIC_W-1:0] cor_y;
   logic                      cor_odd;
   ray_type                   cor_ray;

   logic                      slp_valid;
   logic [SLOPE_W-1:0]        slp_tan;
   logic [SLOPE_W-1:0]        slp_cot;
   ray_type                   slp_ray;

   logic                      walk_valid;
   cast_type                  walk_cast;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff <= '0;
      end else if (csr_write_enable) begin
         wall_map_ff <= csr_write_data;
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      in_ray.px     = req_start_x;
      in_ray.py     = req_start_y;
      in_ray.x_zero = (req_ray_angle == ANGLE_QUART) || (req_ray_angle == ANGLE_3QUART);
      in_ray.x_neg  = (req_ray_angle > ANGLE_QUART) && (req_ray_angle < ANGLE_3QUART);
      in_ray.y_zero = (req_ray_angle == ANGLE_ZERO) || (req_ray_angle == ANGLE_HALF);
      in_ray.y_neg  = req_ray_angle > ANGLE_HALF;
   end

   grc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_angle  (req_ray_angle),
      .in_ray    (in_ray),
      .out_valid (cor_valid),
      .out_x     (cor_x),
      .out_y     (cor_y),
      .out_odd   (cor_odd),
      .out_ray   (cor_ray)
   );

   grc_slope u_slope (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cor_valid),
      .in_x      (cor_x),
      .in_y      (cor_y),
      .in_odd    (cor_odd),
      .in_ray    (cor_ray),
      .out_valid (slp_valid),
      .out_tan   (slp_tan),
      .out_cot   (slp_cot),
      .out_ray   (slp_ray)
   );

   grc_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .wall_map  (wall_map_ff),
      .in_valid  (slp_valid),
      .in_tan    (slp_tan),
      .in_cot    (slp_cot),
      .in_ray    (slp_ray),
      .out_valid (walk_valid),
      .out_cast  (walk_cast)
   );

   grc_pick u_pick (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (walk_valid),
      .in_cast       (walk_cast),
      .out_valid     (rsp_valid),
      .out_hit_x     (rsp_hit_x),
      .out_hit_y     (rsp_hit_y),
      .out_hit_found (rsp_hit_found),
      .out_hit_side  (rsp_hit_side)
   );

endmodule
